FILE: hw/rtl/three_sensor_ultrasonic_ranger_assert.svh
// ----------------------------------------------------------------------------
// Ranger assertion macros
// Shared concurrent assertion forms for the ranger RTL.
// ----------------------------------------------------------------------------
`ifndef THREE_SENSOR_ULTRASONIC_RANGER_ASSERT_SVH
`define THREE_SENSOR_ULTRASONIC_RANGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSUR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSUR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tsur_pkg.sv
// ----------------------------------------------------------------------------
// Ranger package
// Types, register codes and conversion constants for the ultrasonic ranger.
// ----------------------------------------------------------------------------
package tsur_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int TICK_US_W = 11;
  localparam int PERIOD_W  = 8;
  localparam int SPACING_W = 7;
  localparam int CM_W      = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [TICK_US_W-1:0] TICK_US_RST      = 11'd64;
  localparam logic [PERIOD_W-1:0]  CYCLE_PERIOD_RST = 8'd60;
  localparam logic [SPACING_W-1:0] SLOT_SPACING_RST = 7'd20;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_US      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SPACING = 2'd2;

  localparam logic [1:0] TRIG_NONE       = 2'd0;
  localparam logic [1:0] TRIG_FIRE_LEFT  = 2'd1;
  localparam logic [1:0] TRIG_FIRE_MID   = 2'd2;
  localparam logic [1:0] TRIG_FIRE_RIGHT = 2'd3;

  localparam logic [1:0] SENSOR_LEFT  = 2'd0;
  localparam logic [1:0] SENSOR_MID   = 2'd1;
  localparam logic [1:0] SENSOR_RIGHT = 2'd2;

  // Centimeters are floor(us / 58). Results saturate at CM_MAX once the
  // microsecond product reaches 32768 * 58.
  localparam int CM_DIVISOR = 58;
  localparam logic [CM_W-1:0] CM_MAX = 15'h7FFF;
  localparam int SAT_W = 21;
  localparam logic [SAT_W-1:0] CM_SAT_LIMIT = 21'(32768 * CM_DIVISOR);
  // Reciprocal of 58 scaled by 2^27, rounded up; exact for products below 2^21.
  localparam int CM_SHIFT = 27;
  localparam int RECIP_W  = 22;
  localparam logic [RECIP_W-1:0] CM_RECIP = 22'd2314099;

  typedef struct packed {
    logic left_echo;
    logic mid_echo;
    logic right_echo;
    logic count_tick;
    logic sched_tick;
  } in_t;

  typedef struct packed {
    logic [CM_W-1:0] left_cm;
    logic [CM_W-1:0] mid_cm;
    logic [CM_W-1:0] right_cm;
    logic [2:0]      updated;
    logic [1:0]      trigger;
    logic [1:0]      active_sensor;
  } out_t;

  typedef struct packed {
    logic [TICK_US_W-1:0] tick_us;
    logic [PERIOD_W-1:0]  cycle_period;
    logic [SPACING_W-1:0] slot_spacing;
  } cfg_t;

  typedef struct packed {
    logic [2:0] updated;
    logic [1:0] trigger;
    logic [1:0] active_sensor;
  } ctl_t;

endpackage

FILE: hw/rtl/tsur_cfg_regs.sv
// ----------------------------------------------------------------------------
// Ranger configuration registers
// Holds tick length, round period and slot spacing, written by index.
// ----------------------------------------------------------------------------
module tsur_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [tsur_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [tsur_pkg::CFG_DATA_W-1:0]  wr_data,
  output tsur_pkg::cfg_t                   cfg
);
  import tsur_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_TICK_US:      cfg_nxt.tick_us      = wr_data[TICK_US_W-1:0];
        REG_CYCLE_PERIOD: cfg_nxt.cycle_period = wr_data[PERIOD_W-1:0];
        REG_SLOT_SPACING: cfg_nxt.slot_spacing = wr_data[SPACING_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_us      <= TICK_US_RST;
      cfg_r.cycle_period <= CYCLE_PERIOD_RST;
      cfg_r.slot_spacing <= SLOT_SPACING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/tsur_front.sv
// ----------------------------------------------------------------------------
// Ranger front end
// Echo edge handling on the shared counter and the trigger scheduler.
// ----------------------------------------------------------------------------
module tsur_front #(
  parameter int COUNT_BITS = tsur_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  tsur_pkg::in_t                     in_data,
  input  logic [tsur_pkg::PERIOD_W-1:0]     cycle_period,
  input  logic [tsur_pkg::SPACING_W-1:0]    slot_spacing,
  output logic [2:0][COUNT_BITS-1:0]        snap,
  output tsur_pkg::ctl_t                    ctl
);
  import tsur_pkg::*;

  logic [2:0]                  prev_echo_r, prev_echo_nxt;
  logic [COUNT_BITS-1:0]       count_r, count_nxt;
  logic [PERIOD_W-1:0]         phase_r, phase_nxt;
  logic [1:0]                  sensor_r, sensor_nxt;
  logic [2:0][COUNT_BITS-1:0]  snap_r, snap_nxt;
  ctl_t                        ctl_r, ctl_nxt;
  logic [2:0]                  echo;
  logic [COUNT_BITS-1:0]       cnt;
  logic [PERIOD_W:0]           phase_inc;
  logic [1:0]                  trig;

  assign echo = {in_data.right_echo, in_data.mid_echo, in_data.left_echo};

  always_comb begin
    cnt      = count_r;
    snap_nxt = snap_r;
    ctl_nxt  = ctl_r;
    ctl_nxt.updated = 3'b000;
    for (int s = 0; s < 3; s++) begin
      if (echo[s] && !prev_echo_r[s]) begin
        cnt = '0;
      end else if (!echo[s] && prev_echo_r[s]) begin
        snap_nxt[s] = cnt;
        ctl_nxt.updated[s] = 1'b1;
      end
    end
    prev_echo_nxt = echo;
    count_nxt = in_data.count_tick ? cnt + COUNT_BITS'(1) : cnt;

    trig       = TRIG_NONE;
    sensor_nxt = sensor_r;
    phase_nxt  = phase_r;
    phase_inc  = {1'b0, phase_r} + 9'd1;
    if (in_data.sched_tick) begin
      if (phase_r == '0) begin
        trig = TRIG_FIRE_LEFT;
      end else if (phase_r == {1'b0, slot_spacing}) begin
        trig = TRIG_FIRE_MID;
      end else if (phase_r == {slot_spacing, 1'b0}) begin
        trig = TRIG_FIRE_RIGHT;
      end
      if (trig != TRIG_NONE) begin
        sensor_nxt = trig - 2'd1;
      end
      phase_nxt = (phase_inc >= {1'b0, cycle_period}) ? '0 : phase_inc[PERIOD_W-1:0];
    end
    ctl_nxt.trigger       = trig;
    ctl_nxt.active_sensor = sensor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_echo_r <= '0;
      count_r     <= '0;
      phase_r     <= '0;
      sensor_r    <= SENSOR_LEFT;
    end else if (accept) begin
      prev_echo_r <= prev_echo_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      sensor_r    <= sensor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap_r <= snap_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  assign snap = snap_r;
  assign ctl  = ctl_r;

endmodule

FILE: hw/rtl/tsur_cm_lane.sv
// ----------------------------------------------------------------------------
// Ranger distance lane
// Count times tick length, registered, then divided by 58 with saturation.
// ----------------------------------------------------------------------------
module tsur_cm_lane #(
  parameter int COUNT_BITS = tsur_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [COUNT_BITS-1:0]            count_in,
  input  logic [tsur_pkg::TICK_US_W-1:0]   tick_us,
  output logic [tsur_pkg::CM_W-1:0]        cm
);
  import tsur_pkg::*;

  localparam int PROD_W  = COUNT_BITS + TICK_US_W;
  localparam int CMP_W   = (PROD_W > SAT_W) ? PROD_W : SAT_W;
  localparam int QPROD_W = SAT_W + RECIP_W;

  logic [PROD_W-1:0]   prod;
  logic [CMP_W-1:0]    prod_wide;
  logic                sat_r, sat_nxt;
  logic [SAT_W-1:0]    low_r, low_nxt;
  logic [QPROD_W-1:0]  quot;

  always_comb begin
    prod      = PROD_W'(count_in) * PROD_W'(tick_us);
    prod_wide = CMP_W'(prod);
    sat_nxt   = prod_wide >= CMP_W'(CM_SAT_LIMIT);
    low_nxt   = prod_wide[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= sat_nxt;
      low_r <= low_nxt;
    end
  end

  assign quot = QPROD_W'(low_r) * QPROD_W'(CM_RECIP);
  assign cm   = sat_r ? CM_MAX : quot[CM_SHIFT+CM_W-1:CM_SHIFT];

endmodule

FILE: hw/rtl/three_sensor_ultrasonic_ranger.sv
// ----------------------------------------------------------------------------
// Three-sensor ultrasonic ranger
// Echo pulse-width ranging for three sensors with a round-robin trigger.
// ----------------------------------------------------------------------------
// Each input request carries one clock's sample of the three echo lines, the
// count tick and the scheduler tick. Each request yields exactly one result
// request with the three stored distances in centimeters, the update mask,
// the trigger strobe and the active sensor.
// A request is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// One request is taken every cycle unless the output stalls: a three-stage
// pipeline (edge and scheduler stage, multiply stage, divide and store
// stage) moves forward as a whole, and each accepted request reaches its
// result on the output register of the divide and store stage.
// When the receiver stalls a full output register, the whole pipeline holds
// and in_stall rises in the same cycle; it falls as soon as the result drains.
// Configuration writes are always ready and should only be issued while no
// request is in flight.
// Reset clears the echo counter, the phase, the stored distances and the
// pipeline, selects the left sensor and loads the default register values.
// ----------------------------------------------------------------------------
module three_sensor_ultrasonic_ranger #(
  parameter int COUNT_BITS = tsur_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tsur_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tsur_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsur_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsur_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tsur_pkg::*;

  `include "three_sensor_ultrasonic_ranger_assert.svh"

  cfg_t                        cfg;
  logic                        en;
  logic                        accept;
  logic [2:0][COUNT_BITS-1:0]  snap;
  ctl_t                        ctl1;
  ctl_t                        ctl2_r;
  logic                        v1_r, v2_r, out_valid_r;
  logic [2:0][CM_W-1:0]        cm;
  logic [2:0][CM_W-1:0]        dist_r, dist_nxt;
  out_t                        out_data_r, out_data_nxt;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;

  tsur_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tsur_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_data      (in_data),
    .cycle_period (cfg.cycle_period),
    .slot_spacing (cfg.slot_spacing),
    .snap         (snap),
    .ctl          (ctl1)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tsur_cm_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk      (clk),
      .en       (en),
      .count_in (snap[g]),
      .tick_us  (cfg.tick_us),
      .cm       (cm[g])
    );
  end

  always_comb begin
    dist_nxt = dist_r;
    for (int s = 0; s < 3; s++) begin
      if (v2_r && ctl2_r.updated[s]) begin
        dist_nxt[s] = cm[s];
      end
    end
    out_data_nxt.left_cm       = dist_nxt[0];
    out_data_nxt.mid_cm        = dist_nxt[1];
    out_data_nxt.right_cm      = dist_nxt[2];
    out_data_nxt.updated       = ctl2_r.updated;
    out_data_nxt.trigger       = ctl2_r.trigger;
    out_data_nxt.active_sensor = ctl2_r.active_sensor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      dist_r      <= '0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
      dist_r      <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2_r <= ctl1;
      if (v2_r) begin
        out_data_r <= out_data_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TSUR_ASSERT_IMP(a_trig_sets_sensor,
    out_valid && out_data.trigger != TRIG_NONE,
    out_data.active_sensor == out_data.trigger - 2'd1,
    "Active sensor does not follow the trigger.")

  `TSUR_ASSERT_NXT(a_request_reaches_output,
    accept ##1 en ##1 en,
    out_valid,
    "Accepted request did not reach the output register.")

  `TSUR_ASSERT_NXT(a_left_holds,
    en && v2_r && !ctl2_r.updated[0],
    $stable(dist_r[0]),
    "Left distance changed without a falling echo edge.")

endmodule

FILE: tb/three_sensor_ultrasonic_ranger_test.sv
// ----------------------------------------------------------------------------
// Ultrasonic ranger testbench
// Drives echo, count and scheduler samples into the ranger under random
// handshake pressure and checks every result request field by field against
// a sample-by-sample predictor of the ranging and trigger logic. The run steps
// through several register settings, including zero and masked values.
// ----------------------------------------------------------------------------
module three_sensor_ultrasonic_ranger_test;
  import tsur_pkg::*;

  localparam int LATENCY = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  three_sensor_ultrasonic_ranger u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state and register copies.
  logic [TICK_US_W-1:0] tick_us_cfg = TICK_US_RST;
  logic [PERIOD_W-1:0] period_cfg = CYCLE_PERIOD_RST;
  logic [SPACING_W-1:0] spacing_cfg = SLOT_SPACING_RST;
  logic [2:0] echo_seen = '0;
  logic [COUNT_BITS_DEF-1:0] echo_ticks = '0;
  logic [7:0] sched_phase = '0;
  logic [CM_W-1:0] range_cm [3] = '{default: '0};
  logic [1:0] sensor_sel = SENSOR_LEFT;

  in_t pending_samples[$];
  out_t expected_results[$];

  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  bit steady_tail = 1'b0;
  bit long_hold_armed = 1'b0;

  int send_gap = 0;
  int send_pct = 10;
  int send_epoch = 0;
  int stall_burst = 0;
  int stall_pct = 10;
  int stall_epoch = 0;
  int hold_left = 0;
  out_t want;

  function automatic logic [CM_W-1:0] to_cm(input logic [COUNT_BITS_DEF-1:0] ticks);
    longint q;
    q = (longint'(ticks) * longint'(tick_us_cfg)) / CM_DIVISOR;
    return (q > longint'(CM_MAX)) ? CM_MAX : CM_W'(q);
  endfunction

  function automatic out_t range_step(input in_t s);
    logic [2:0] lines;
    logic [2:0] stored;
    logic [1:0] fire;
    out_t r;
    lines = {s.right_echo, s.mid_echo, s.left_echo};
    stored = '0;
    fire = TRIG_NONE;
    for (int k = 0; k < 3; k++) begin
      if (lines[k] && !echo_seen[k]) begin
        echo_ticks = '0;
      end else if (!lines[k] && echo_seen[k]) begin
        range_cm[k] = to_cm(echo_ticks);
        stored[k] = 1'b1;
      end
    end
    echo_seen = lines;
    if (s.count_tick) begin
      echo_ticks = echo_ticks + COUNT_BITS_DEF'(1);
    end
    if (s.sched_tick) begin
      if (sched_phase == 8'd0) begin
        fire = TRIG_FIRE_LEFT;
      end else if (int'(sched_phase) == int'(spacing_cfg)) begin
        fire = TRIG_FIRE_MID;
      end else if (int'(sched_phase) == 2 * int'(spacing_cfg)) begin
        fire = TRIG_FIRE_RIGHT;
      end
      case (fire)
        TRIG_FIRE_LEFT: sensor_sel = SENSOR_LEFT;
        TRIG_FIRE_MID: sensor_sel = SENSOR_MID;
        TRIG_FIRE_RIGHT: sensor_sel = SENSOR_RIGHT;
        default: ;
      endcase
      sched_phase = (int'(sched_phase) + 1 >= int'(period_cfg)) ? 8'd0 : sched_phase + 8'd1;
    end
    r.left_cm = range_cm[0];
    r.mid_cm = range_cm[1];
    r.right_cm = range_cm[2];
    r.updated = stored;
    r.trigger = fire;
    r.active_sensor = sensor_sel;
    return r;
  endfunction

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic add_req(input logic [2:0] lines, input bit ct, input bit st);
    in_t req;
    req = '{left_echo: lines[0], mid_echo: lines[1], right_echo: lines[2],
            count_tick: ct, sched_tick: st};
    pending_samples.push_back(req);
  endtask

  task automatic echo_pulse(input logic [2:0] lines, input int len, input int count_pct,
                            input int sched_pct);
    add_req(3'b000, chance(count_pct), chance(sched_pct));
    repeat (len) add_req(lines, chance(count_pct), chance(sched_pct));
    add_req(3'b000, chance(count_pct), chance(sched_pct));
  endtask

  task automatic random_traffic(input int n_req, input int sched_pct);
    int made;
    int kind;
    int len;
    logic [2:0] lines;
    made = 0;
    while (made < n_req) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 40);
      lines = 3'($urandom_range(1, 7));
      if (kind < 6) begin
        echo_pulse(lines, len, 70, sched_pct);
        made += len + 2;
      end else if (kind < 8) begin
        repeat (len / 4 + 1) begin
          add_req(3'($urandom), chance(50), chance(sched_pct));
          made++;
        end
      end else begin
        // Other echo lines start or stop while a pulse is still high.
        add_req(3'b000, chance(70), chance(sched_pct));
        repeat (len) begin
          if (chance(15)) lines ^= 3'(1 << $urandom_range(0, 2));
          add_req(lines, chance(70), chance(sched_pct));
        end
        made += len + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_TICK_US: tick_us_cfg = val[TICK_US_W-1:0];
      REG_CYCLE_PERIOD: period_cfg = val[PERIOD_W-1:0];
      REG_SLOT_SPACING: spacing_cfg = val[SPACING_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string field, input int exp_val, input int got_val);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(range_step(in_data));
        requests_sent++;
      end
      send_epoch++;
      if (send_epoch % 64 == 0) send_pct = pick_idle_pct();
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!steady_tail && chance(send_pct)) begin
          send_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_epoch++;
      if (stall_epoch % 64 == 0) stall_pct = pick_idle_pct();
      if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b1;
      end else if (!steady_tail && chance(stall_pct)) begin
        stall_burst = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.left_cm !== want.left_cm)
          flag_mismatch("left_cm", int'(want.left_cm), int'(out_data.left_cm));
        if (out_data.mid_cm !== want.mid_cm)
          flag_mismatch("mid_cm", int'(want.mid_cm), int'(out_data.mid_cm));
        if (out_data.right_cm !== want.right_cm)
          flag_mismatch("right_cm", int'(want.right_cm), int'(out_data.right_cm));
        if (out_data.updated !== want.updated)
          flag_mismatch("updated", int'(want.updated), int'(out_data.updated));
        if (out_data.trigger !== want.trigger)
          flag_mismatch("trigger", int'(want.trigger), int'(out_data.trigger));
        if (out_data.active_sensor !== want.active_sensor)
          flag_mismatch("active_sensor", int'(want.active_sensor),
                        int'(out_data.active_sensor));
      end
    end
  end

  initial begin
    #6000000;
    $display("%0t: timeout", $time);
    $display("three_sensor_ultrasonic_ranger: mismatch");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Default settings: same-sample edges on the shared counter.
    add_req(3'b000, 1'b0, 1'b0);
    add_req(3'b000, 1'b0, 1'b1);
    add_req(3'b111, 1'b1, 1'b1);
    repeat (5) add_req(3'b111, 1'b1, 1'b0);
    add_req(3'b110, 1'b0, 1'b1);
    add_req(3'b101, 1'b1, 1'b0);
    repeat (3) add_req(3'b101, 1'b1, 1'b1);
    add_req(3'b000, 1'b0, 1'b0);
    add_req(3'b000, 1'b0, 1'b0);
    add_req(3'b111, 1'b0, 1'b0);
    add_req(3'b000, 1'b0, 1'b1);
    add_req(3'b010, 1'b1, 1'b0);
    repeat (4) add_req(3'b010, 1'b1, 1'b1);
    add_req(3'b100, 1'b1, 1'b0);
    add_req(3'b000, 1'b1, 1'b1);
    settle();

    write_reg(REG_TICK_US, 11'd1024);
    write_reg(REG_CYCLE_PERIOD, 11'd3);
    write_reg(REG_SLOT_SPACING, 11'd1);
    random_traffic(60, 50);
    settle();

    write_reg(REG_TICK_US, 11'd1);
    write_reg(REG_CYCLE_PERIOD, 11'd255);
    write_reg(REG_SLOT_SPACING, 11'd85);
    random_traffic(120, 95);
    settle();

    // The phase may sit above the new period here.
    write_reg(REG_TICK_US, 11'd0);
    write_reg(REG_CYCLE_PERIOD, 11'd1);
    write_reg(REG_SLOT_SPACING, 11'd0);
    random_traffic(50, 60);
    settle();

    write_reg(REG_TICK_US, 11'h7FF);
    write_reg(REG_CYCLE_PERIOD, 11'h10A);
    write_reg(REG_SLOT_SPACING, 11'h7C5);
    write_reg(REG_UNUSED, 11'h555);
    random_traffic(30, 60);
    settle();
    write_reg(REG_CYCLE_PERIOD, 11'h700);
    random_traffic(30, 60);
    settle();

    write_reg(REG_TICK_US, 11'($urandom_range(1, 1024)));
    write_reg(REG_CYCLE_PERIOD, 11'($urandom_range(3, 255)));
    write_reg(REG_SLOT_SPACING, 11'($urandom_range(1, 85)));
    write_reg(REG_UNUSED, 11'($urandom));
    long_hold_armed = 1'b1;
    random_traffic(80, 70);
    settle();

    // Back to defaults with no idling.
    write_reg(REG_TICK_US, 11'(TICK_US_RST));
    write_reg(REG_CYCLE_PERIOD, 11'(CYCLE_PERIOD_RST));
    write_reg(REG_SLOT_SPACING, 11'(SLOT_SPACING_RST));
    steady_tail = 1'b1;
    random_traffic(40, 50);
    settle();

    $display("Sent %0d sample requests and checked %0d results over %0d register writes.",
             requests_sent, results_checked, reg_writes);
    $display("Settings covered zero, masked and extreme tick, period and spacing values.");
    if (mismatches == 0) begin
      $display("three_sensor_ultrasonic_ranger: match");
    end else begin
      $display("three_sensor_ultrasonic_ranger: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tsur_pkg.sv
hw/rtl/tsur_cfg_regs.sv
hw/rtl/tsur_front.sv
hw/rtl/tsur_cm_lane.sv
hw/rtl/three_sensor_ultrasonic_ranger.sv
tb/three_sensor_ultrasonic_ranger_test.sv
